>>> hw/rtl/mrfc_pkg.sv
package mrfc_pkg;

    localparam logic [7:0]  FC_RAW      = 8'h41;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [15:0] COIL_ON     = 16'hFF00;
    localparam logic [7:0]  COUNT_LIMIT = 8'd251;
    localparam logic [8:0]  IDX_MAX     = 9'd511;
    localparam int          OUT_BYTES   = 3;

    typedef enum logic [1:0] {
        VERDICT_INVALID = 2'd0,
        VERDICT_VALID   = 2'd1,
        VERDICT_UNKNOWN = 2'd2
    } t_verdict;

    typedef struct packed {
        logic [8:0] expected_length;
        logic [7:0] function_code;
        t_verdict   verdict;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result result;
    } t_push;

endpackage

>>> hw/rtl/modbus_rtu_frame_checker.sv
// Throughput: one byte per cycle; a new byte is taken while earlier verdicts wait.
// The verdict is written into the queue when the last byte is taken (front state
// update and queue write), then moves on into the m_axis output register.
// The front stalls only when the two-entry verdict queue is full.
// Reset (i_rst_n low, synchronous) clears frame state, the queue and the mode
// (request checking).
module modbus_rtu_frame_checker import mrfc_pkg::*; #(
    parameter int MAX_FRAME_BYTES = 256,
    parameter int CRC_SPAN_LIMIT  = 254
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,     // [0] check_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [1:0] verdict, [9:2] function_code,
                                        // [18:10] expected_length, [23:19] zero
);

    t_push   push;
    logic    q_full;
    logic    q_valid;
    t_result q_result;
    logic    q_pop;

    assign o_cfg_ready = 1'b1;

    mrfc_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
        .CRC_SPAN_LIMIT (CRC_SPAN_LIMIT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_byte     (s_axis_tdata),
        .i_last     (s_axis_tlast),
        .i_q_full   (q_full),
        .o_push     (push)
    );

    mrfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_result(q_result),
        .i_pop   (q_pop)
    );

    mrfc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_result(q_result),
        .o_pop     (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata)
    );

endmodule

>>> hw/rtl/mrfc_front.sv
module mrfc_front import mrfc_pkg::*; #(
    parameter int MAX_FRAME_BYTES = 256,
    parameter int CRC_SPAN_LIMIT  = 254
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic       i_q_full,
    output t_push      o_push
);

    localparam logic [9:0] MaxBytes = 10'(MAX_FRAME_BYTES);
    localparam logic [9:0] CrcStop  = 10'(CRC_SPAN_LIMIT + 2);

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [8:0] fixed_length(input logic mode, input logic [7:0] fc,
                                                input logic [7:0] cnt);
        logic [8:0] len;
        len = '0;
        if (!mode) begin
            if (fc <= 8'd6) len = 9'd8;
            else if (fc == 8'd15 || fc == 8'd16) len = 9'd9 + {1'b0, cnt};
        end else begin
            if (fc <= 8'd4) len = {1'b0, cnt} + 9'd5;
            else if (fc == 8'd5 || fc == 8'd6 || fc == 8'd15 || fc == 8'd16) len = 9'd8;
        end
        return len;
    endfunction

    logic        r_mode;
    logic [8:0]  r_idx,   n_idx;
    logic [15:0] r_crc,   n_crc;
    logic [7:0]  r_func,  n_func;
    logic [7:0]  r_count, n_count;
    logic [15:0] r_coil,  n_coil;
    logic [7:0]  r_held0, r_held1;
    logic        r_match, n_match;
    logic [8:0]  len;
    logic [9:0]  p_ext;
    logic [9:0]  n_len;
    logic        tail_ok;
    logic        accept;
    t_verdict    verdict;
    logic [8:0]  explen;
    logic        ok;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign p_ext   = {1'b0, r_idx};
    assign n_len   = p_ext + 10'd1;

    always_comb begin
        n_func  = (r_idx == 9'd1) ? i_byte : r_func;
        n_count = r_count;
        if ((r_idx == 9'd2 && r_mode) || (r_idx == 9'd6 && !r_mode)) n_count = i_byte;
        n_coil = r_coil;
        if (r_idx == 9'd4) n_coil[15:8] = i_byte;
        if (r_idx == 9'd5) n_coil[7:0]  = i_byte;
        n_crc = (r_idx >= 9'd2 && p_ext < CrcStop) ? crc_byte(r_crc, r_held0) : r_crc;
        tail_ok = (n_crc[7:0] == r_held1) && (n_crc[15:8] == i_byte);
        len = fixed_length(r_mode, n_func, n_count);
        n_match = (len != 9'd0 && r_idx == len - 9'd1) ? tail_ok : r_match;
        n_idx = (r_idx < IDX_MAX) ? r_idx + 9'd1 : IDX_MAX;
    end

    always_comb begin
        verdict = VERDICT_INVALID;
        ok      = 1'b0;
        explen  = len;
        if (n_func == FC_RAW) explen = n_len[9] ? IDX_MAX : n_len[8:0];
        if (n_len <= MaxBytes) begin
            if (!r_mode) begin
                if (n_func == FC_RAW) begin
                    ok = (n_len >= 10'd3) && tail_ok;
                    verdict = ok ? VERDICT_VALID : VERDICT_INVALID;
                end else if (len == 9'd0) begin
                    verdict = VERDICT_UNKNOWN;
                end else begin
                    ok = (n_len >= {1'b0, len}) && n_match;
                    verdict = ok ? VERDICT_VALID : VERDICT_INVALID;
                end
            end else begin
                if (n_func == FC_RAW) begin
                    verdict = VERDICT_VALID;
                end else if (len != 9'd0) begin
                    ok = (n_len >= {1'b0, len}) && n_match;
                    if (n_func <= 8'd4 && n_count >= COUNT_LIMIT) ok = 1'b0;
                    if (n_func == 8'd5 && n_coil != COIL_ON && n_coil != 16'h0000) ok = 1'b0;
                    verdict = ok ? VERDICT_VALID : VERDICT_INVALID;
                end
            end
        end
    end

    assign o_push.valid                  = accept && i_last;
    assign o_push.result.verdict         = verdict;
    assign o_push.result.function_code   = n_func;
    assign o_push.result.expected_length = explen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_crc   <= CRC_INIT;
            r_func  <= '0;
            r_count <= '0;
            r_coil  <= '0;
            r_held0 <= '0;
            r_held1 <= '0;
            r_match <= 1'b0;
        end else if (accept) begin
            if (i_last) begin
                r_idx   <= '0;
                r_crc   <= CRC_INIT;
                r_func  <= '0;
                r_count <= '0;
                r_coil  <= '0;
                r_held0 <= '0;
                r_held1 <= '0;
                r_match <= 1'b0;
            end else begin
                r_idx   <= n_idx;
                r_crc   <= n_crc;
                r_func  <= n_func;
                r_count <= n_count;
                r_coil  <= n_coil;
                r_held0 <= r_held1;
                r_held1 <= i_byte;
                r_match <= n_match;
            end
        end
    end

endmodule

>>> hw/rtl/mrfc_queue.sv
module mrfc_queue import mrfc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_full,
    output logic    o_valid,
    output t_result o_result,
    input  logic    i_pop
);

    t_result     r_mem [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt, n_cnt;
    logic        do_pop;

    assign o_full   = (r_cnt == 2'd2);
    assign o_valid  = (r_cnt != 2'd0);
    assign o_result = r_mem[r_rp];
    assign do_pop   = i_pop && o_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push.valid && !do_pop) n_cnt = r_cnt + 2'd1;
        if (!i_push.valid && do_pop) n_cnt = r_cnt - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wp] <= i_push.result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push.valid) r_wp <= ~r_wp;
            if (do_pop)       r_rp <= ~r_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> hw/rtl/mrfc_back.sv
module mrfc_back import mrfc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  t_result                i_q_result,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [8*OUT_BYTES-1:0] o_data
);

    logic    r_valid;
    t_result r_result;

    assign o_pop   = i_q_valid && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_data  = {{(8*OUT_BYTES - $bits(t_result)){1'b0}}, r_result};

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= i_q_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

>>> hw/rtl/mrfc_checker.sv
module mrfc_checker import mrfc_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    logic [1:0] verdict;
    logic [8:0] explen;

    assign verdict = m_axis_tdata[1:0];
    assign explen  = m_axis_tdata[18:10];

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_unknown_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && verdict == VERDICT_UNKNOWN |-> explen == 9'd0)
        else $error("unknown function with nonzero length");

    a_valid_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && verdict == VERDICT_VALID |-> explen >= 9'd2)
        else $error("valid verdict with too short length");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:19] == 5'd0 && verdict != 2'd3)
        else $error("bad result encoding");

endmodule

bind modbus_rtu_frame_checker mrfc_checker u_mrfc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

>>> dv/modbus_rtu_frame_checker_monitor.sv
`timescale 1ns / 1ps

package mrfc_tb_pkg;
    import mrfc_pkg::*;

    localparam logic       MODE_REQUEST   = 1'b0;
    localparam logic       MODE_RESPONSE  = 1'b1;

    localparam logic [7:0] FC_READ_FIRST  = 8'd0;
    localparam logic [7:0] FC_READ_LAST   = 8'd4;
    localparam logic [7:0] FC_WRITE_COIL  = 8'd5;
    localparam logic [7:0] FC_WRITE_REG   = 8'd6;
    localparam logic [7:0] FC_WRITE_COILS = 8'd15;
    localparam logic [7:0] FC_WRITE_REGS  = 8'd16;
    localparam logic [7:0] FC_UNKNOWN_TOP = 8'hFF;

    function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

endpackage

module mrfc_verdict_checker import mrfc_pkg::*, mrfc_tb_pkg::*; #(
    parameter int MAX_FRAME_BYTES = 256,
    parameter int CRC_SPAN_LIMIT  = 254
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_data,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [7:0]  i_req_data,
    input  logic        i_req_last,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [23:0] i_res_data,
    output int          o_fail_count,
    output int          o_pending
);

    logic        check_mode = MODE_REQUEST;
    int          byte_pos;
    logic [15:0] crc_acc;
    logic [7:0]  func_code;
    logic [7:0]  count_val;
    logic [15:0] coil_word;
    logic [7:0]  tail_bytes [2];
    logic        tail_ok;
    t_result     verdict_q [$];
    int          fails = 0;

    function automatic int frame_len(input logic m, input logic [7:0] f, input logic [7:0] c);
        if (m == MODE_REQUEST) begin
            if (f <= FC_WRITE_REG) return 8;
            if (f == FC_WRITE_COILS || f == FC_WRITE_REGS) return 9 + c;
            return 0;
        end
        if (f <= FC_READ_LAST) return c + 5;
        if (f == FC_WRITE_COIL || f == FC_WRITE_REG || f == FC_WRITE_COILS ||
            f == FC_WRITE_REGS) return 8;
        return 0;
    endfunction

    task automatic clear_frame();
        byte_pos      = 0;
        crc_acc       = CRC_INIT;
        func_code     = '0;
        count_val     = '0;
        coil_word     = '0;
        tail_bytes[0] = '0;
        tail_bytes[1] = '0;
        tail_ok       = 1'b0;
    endtask

    task automatic take_byte(input logic [7:0] b, input logic last);
        int      p;
        int      len;
        int      n;
        logic    ok;
        t_result res;
        p = byte_pos;
        if (p == 1) func_code = b;
        if (p == 2 && check_mode == MODE_RESPONSE) count_val = b;
        if (p == 6 && check_mode == MODE_REQUEST) count_val = b;
        if (p == 4) coil_word[15:8] = b;
        if (p == 5) coil_word[7:0] = b;
        if (p >= 2 && p - 2 < CRC_SPAN_LIMIT) crc_acc = crc16_next(crc_acc, tail_bytes[0]);
        tail_bytes[0] = tail_bytes[1];
        tail_bytes[1] = b;
        len = frame_len(check_mode, func_code, count_val);
        if (len > 0 && p == len - 1) tail_ok = (crc_acc == {tail_bytes[1], tail_bytes[0]});
        if (p < IDX_MAX) byte_pos = p + 1;
        if (!last) return;

        n = p + 1;
        res.function_code = func_code;
        res.verdict       = VERDICT_INVALID;
        if (func_code == FC_RAW) res.expected_length = (n > IDX_MAX) ? IDX_MAX : 9'(n);
        else res.expected_length = 9'(len);
        if (n <= MAX_FRAME_BYTES) begin
            if (func_code == FC_RAW) begin
                if (check_mode == MODE_RESPONSE ||
                    (n >= 3 && crc_acc == {tail_bytes[1], tail_bytes[0]}))
                    res.verdict = VERDICT_VALID;
            end else if (len == 0) begin
                if (check_mode == MODE_REQUEST) res.verdict = VERDICT_UNKNOWN;
            end else begin
                ok = (n >= len) && tail_ok;
                if (check_mode == MODE_RESPONSE && func_code <= FC_READ_LAST &&
                    count_val >= COUNT_LIMIT) ok = 1'b0;
                if (check_mode == MODE_RESPONSE && func_code == FC_WRITE_COIL &&
                    coil_word != COIL_ON && coil_word != 16'h0000) ok = 1'b0;
                if (ok) res.verdict = VERDICT_VALID;
            end
        end
        verdict_q.push_back(res);
        clear_frame();
    endtask

    task automatic check_result(input logic [23:0] data);
        t_result got;
        t_result want;
        got = t_result'(data[18:0]);
        if (verdict_q.size() == 0) begin
            $error("result with no verdict pending: tdata %h", data);
            fails++;
            return;
        end
        want = verdict_q.pop_front();
        if (got.verdict !== want.verdict) begin
            $error("verdict: expected %0d, actual %0d", want.verdict, got.verdict);
            fails++;
        end
        if (got.function_code !== want.function_code) begin
            $error("function_code: expected %0d, actual %0d",
                   want.function_code, got.function_code);
            fails++;
        end
        if (got.expected_length !== want.expected_length) begin
            $error("expected_length: expected %0d, actual %0d",
                   want.expected_length, got.expected_length);
            fails++;
        end
        if (data[23:19] !== 5'd0) begin
            $error("pad: expected 0, actual %0d", data[23:19]);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            check_mode = MODE_REQUEST;
            clear_frame();
            verdict_q.delete();
        end else begin
            if (i_res_valid && i_res_ready) check_result(i_res_data);
            if (i_req_valid && i_req_ready) take_byte(i_req_data, i_req_last);
            if (i_cfg_valid && i_cfg_ready) check_mode = i_cfg_data;
        end
        o_fail_count <= fails;
        o_pending    <= verdict_q.size();
    end

endmodule

>>> dv/modbus_rtu_frame_checker_tb.sv
`timescale 1ns / 1ps

module modbus_rtu_frame_checker_tb;
    import mrfc_pkg::*;
    import mrfc_tb_pkg::*;

    localparam int CYCLE_LIMIT = 300_000;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data    = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] data_byte
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;            // [1:0] verdict, [9:2] function_code,
                                          // [18:10] expected_length, [23:19] zero

    int          fail_count;
    int          pending;
    int          snd_idle    = 34;
    int          rcv_idle    = 51;
    int          hold_cycles = 0;
    int          bytes_sent  = 0;
    int          frames_sent = 0;
    int          cycle_cnt   = 0;
    logic        cur_mode    = MODE_REQUEST;
    logic [7:0]  frame_q [$];

    modbus_rtu_frame_checker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    mrfc_verdict_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_req_last   (s_axis_tlast),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("** modbus_rtu_frame_checker: FAILED **");
        $finish;
    end

    // hold off for hold_cycles, otherwise stall at random
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                hold_cycles--;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle);
            end
        end
    end

    task automatic put_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < snd_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_q[i]) put_byte(frame_q[i], i == frame_q.size() - 1);
        frames_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_mode = m;
    endtask

    task automatic add_random(input int n);
        repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic add_crc();
        logic [15:0] c;
        c = CRC_INIT;
        foreach (frame_q[i]) c = crc16_next(c, frame_q[i]);
        frame_q.push_back(c[7:0]);
        frame_q.push_back(c[15:8]);
    endtask

    // n is the count byte, or the payload size for raw and unknown codes; fixed-length codes ignore it
    task automatic make_frame(input logic m, input logic [7:0] f, input int n,
                              input logic [15:0] coil);
        frame_q.delete();
        add_random(1);
        frame_q.push_back(f);
        if (f == FC_RAW) begin
            add_random(n);
        end else if (m == MODE_REQUEST && (f == FC_WRITE_COILS || f == FC_WRITE_REGS)) begin
            add_random(4);
            frame_q.push_back(8'(n));
            add_random(n);
        end else if (m == MODE_REQUEST && f <= FC_WRITE_REG) begin
            add_random(4);
        end else if (m == MODE_RESPONSE && f <= FC_READ_LAST) begin
            frame_q.push_back(8'(n));
            add_random(n);
        end else if (m == MODE_RESPONSE && f == FC_WRITE_COIL) begin
            add_random(2);
            frame_q.push_back(coil[15:8]);
            frame_q.push_back(coil[7:0]);
        end else if (m == MODE_RESPONSE && (f == FC_WRITE_REG || f == FC_WRITE_COILS ||
                                            f == FC_WRITE_REGS)) begin
            add_random(4);
        end else begin
            add_random(n);
        end
        add_crc();
    endtask

    task automatic mangle();
        int pos;
        case ($urandom_range(0, 2))
            0: begin
                pos = $urandom_range(0, frame_q.size() - 1);
                frame_q[pos] ^= 8'(1 << $urandom_range(0, 7));
            end
            1: repeat ($urandom_range(1, frame_q.size() - 1)) void'(frame_q.pop_back());
            default: add_random($urandom_range(1, 4));
        endcase
    endtask

    task automatic random_frame();
        logic [7:0]  f;
        logic [15:0] coil;
        logic        m;
        int          n;
        m = ($urandom_range(0, 9) == 0) ? ~cur_mode : cur_mode;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
        case ($urandom_range(0, 3))
            0: coil = COIL_ON;
            1: coil = 16'h0000;
            default: coil = 16'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3: f = 8'($urandom_range(FC_READ_FIRST, FC_WRITE_REG));
            4, 5: f = $urandom_range(0, 1) ? FC_WRITE_COILS : FC_WRITE_REGS;
            6: f = FC_RAW;
            7: f = FC_WRITE_COIL;
            8: f = 8'($urandom_range(FC_READ_FIRST, FC_READ_LAST));
            default: f = 8'($urandom_range(0, 255));
        endcase
        make_frame(m, f, n, coil);
        if ($urandom_range(0, 99) < 25) begin
            mangle();
        end else if ($urandom_range(0, 99) < 10) begin
            frame_q.delete();
            add_random($urandom_range(1, 12));
        end
        send_frame();
    endtask

    task automatic run_phase(input int snd, input int rcv, input int target);
        int stop_bytes;
        int stop_frames;
        snd_idle    = snd;
        rcv_idle    = rcv;
        stop_bytes  = bytes_sent + target;
        stop_frames = frames_sent + 4;
        while (bytes_sent < stop_bytes || frames_sent < stop_frames) begin
            if ($urandom_range(0, 9) == 0) write_mode(1'($urandom_range(0, 1)));
            random_frame();
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_mode(MODE_REQUEST);

        make_frame(MODE_REQUEST, FC_READ_FIRST, 0, '0);
        send_frame();
        make_frame(MODE_REQUEST, FC_WRITE_REG, 0, '0);
        send_frame();
        make_frame(MODE_REQUEST, FC_READ_LAST, 0, '0);
        frame_q[7] ^= 8'h80;
        send_frame();
        make_frame(MODE_REQUEST, FC_WRITE_REGS, 4, '0);
        send_frame();
        make_frame(MODE_REQUEST, FC_WRITE_COILS, 0, '0);
        send_frame();
        make_frame(MODE_REQUEST, FC_RAW, 1, '0);
        send_frame();
        frame_q.delete();
        add_random(1);
        frame_q.push_back(FC_RAW);
        send_frame();
        make_frame(MODE_REQUEST, FC_UNKNOWN_TOP, 3, '0);
        send_frame();
        make_frame(MODE_REQUEST, FC_UNKNOWN_TOP, 253, '0);
        send_frame();
        make_frame(MODE_REQUEST, FC_READ_LAST, 0, '0);
        repeat (3) void'(frame_q.pop_back());
        send_frame();
        frame_q.delete();
        add_random(1);
        send_frame();
        make_frame(MODE_REQUEST, FC_READ_FIRST, 0, '0);
        add_random(3);
        send_frame();

        // switch mode with a frame half received
        make_frame(MODE_RESPONSE, FC_WRITE_REG, 0, '0);
        for (int i = 0; i < 3; i++) put_byte(frame_q[i], 1'b0);
        write_mode(MODE_RESPONSE);
        for (int i = 3; i < frame_q.size(); i++) put_byte(frame_q[i], i == frame_q.size() - 1);
        frames_sent++;

        make_frame(MODE_RESPONSE, FC_READ_FIRST, 0, '0);
        send_frame();
        make_frame(MODE_RESPONSE, FC_READ_LAST, 4, '0);
        send_frame();
        make_frame(MODE_RESPONSE, FC_WRITE_COIL, 0, COIL_ON);
        send_frame();
        make_frame(MODE_RESPONSE, FC_WRITE_COIL, 0, 16'h0000);
        send_frame();
        make_frame(MODE_RESPONSE, FC_WRITE_COIL, 0, 16'h00FF);
        send_frame();
        make_frame(MODE_RESPONSE, FC_WRITE_REGS, 0, '0);
        send_frame();
        make_frame(MODE_RESPONSE, FC_WRITE_COILS, 0, '0);
        send_frame();
        make_frame(MODE_RESPONSE, FC_RAW, 5, '0);
        frame_q[frame_q.size() - 1] ^= 8'h01;
        send_frame();
        make_frame(MODE_RESPONSE, FC_UNKNOWN_TOP, 3, '0);
        send_frame();
        write_mode(MODE_REQUEST);

        // hold the result side and flood short frames until the input stalls
        snd_idle    = 0;
        hold_cycles = 300;
        repeat (16) begin
            frame_q.delete();
            add_random(2);
            send_frame();
        end
        wait_drained();

        run_phase(34, 51, 50);
        run_phase(51, 34, 50);
        run_phase(0, 0, 50);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** modbus_rtu_frame_checker: PASSED **");
        end else begin
            $display("** modbus_rtu_frame_checker: FAILED **");
        end
        $finish;
    end

endmodule
